### design/voxel_hash_point_fuser_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel hash point fuser
// Concurrent checks that disappear when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef VOXEL_HASH_POINT_FUSER_CORE_ASSERT_SVH
`define VOXEL_HASH_POINT_FUSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define VHPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("vhpf assertion failed");
// A condition that must never be true outside reset.
`define VHPF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `VHPF_ASSERT(lbl, clk, rstn, !(cond))
`else
`define VHPF_ASSERT(lbl, clk, rstn, prop)
`define VHPF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### design/vhpf_pkg.sv
// ----------------------------------------------------------------------------
// vhpf_pkg
// Types, codes and constants shared by the voxel hash point fuser.
// ----------------------------------------------------------------------------
package vhpf_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 4096;
  localparam int unsigned AXIS_BITS_DEF   = 21;

  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned PACC_W = 51;
  localparam int unsigned NACC_W = 34;
  localparam int unsigned REP_W  = 12;
  localparam int unsigned OCC_W  = 13;
  localparam int unsigned SCALE_SHIFT = 28;

  localparam logic [63:0] HASH_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    CMD_FUSE  = 2'd0,
    CMD_SEED  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OC_HIT       = 3'd0,
    OC_NEW       = 3'd1,
    OC_SAT       = 3'd2,
    OC_SEEDED    = 3'd3,
    OC_SEED_DROP = 3'd4,
    OC_RANGE     = 3'd5,
    OC_FULL      = 3'd6,
    OC_CLEARED   = 3'd7
  } outcome_e;

  typedef enum logic [2:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5,
    REG_INV_VOX = 3'd6,
    REG_SAT_LIM = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [15:0] in_norm_x;
    logic signed [15:0] in_norm_y;
    logic signed [15:0] in_norm_z;
    logic [15:0]        in_radius;
  } point_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic               kept;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_norm_x;
    logic signed [15:0] out_norm_y;
    logic signed [15:0] out_norm_z;
    logic [15:0]        out_radius;
    logic [REP_W-1:0]   representative_index;
    logic [OCC_W-1:0]   voxels_in_use;
  } result_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [47:0] wdata;
  } cfg_t;

  // Signed Q1.14 coefficient of one column of a packed rotation row.
  function automatic logic signed [15:0] coef(input logic [47:0] row, input logic [1:0] col);
    logic signed [15:0] c;
    unique case (col)
      2'd0:    c = row[15:0];
      2'd1:    c = row[31:16];
      default: c = row[47:32];
    endcase
    return c;
  endfunction

endpackage

### design/vhpf_stream_if.sv
// ----------------------------------------------------------------------------
// vhpf_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface vhpf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/vhpf_ram.sv
// ----------------------------------------------------------------------------
// vhpf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vhpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### design/vhpf_mul.sv
// ----------------------------------------------------------------------------
// vhpf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vhpf_mul (
  input  logic                            clk_i,
  input  logic signed [vhpf_pkg::MUL_W-1:0]  a_i,
  input  logic signed [vhpf_pkg::MUL_W-1:0]  b_i,
  output logic signed [vhpf_pkg::PROD_W-1:0] p_o
);
  import vhpf_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

### design/voxel_hash_point_fuser_core.sv
// ----------------------------------------------------------------------------
// voxel_hash_point_fuser_core
// Transforms points, maps them to voxels and fuses them in a hash table.
// ----------------------------------------------------------------------------
// Usage: points enter on in_i (valid/ready), one result item per point leaves
// on out_o (valid/ready), and registers are written on cfg_i, which is always
// ready. A command fuses a point, seeds a point or clears the table.
// One shared 34 x 34 multiplier does all multiplications. A fuse runs the
// rotation, scaling and hash after acceptance, then probes table slots; a
// seed skips the rotation and runs the scaling, hash and probes. The result
// is presented in the cycle after the last probe. The probe loop reads one
// slot at a time from the table RAM and checks it before the next read.
// A clear sweeps the table, one slot per cycle. After reset the same sweep
// runs over every slot before the first item is taken; configuration writes
// are taken meanwhile.
// The block holds one item at a time: in_i is ready only when idle, and a
// result waits on out_o, holding the block, until the receiver takes it.
// ----------------------------------------------------------------------------
`include "voxel_hash_point_fuser_core_assert.svh"

module voxel_hash_point_fuser_core #(
  parameter int unsigned TABLE_SLOTS = vhpf_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned AXIS_BITS   = vhpf_pkg::AXIS_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vhpf_stream_if.sink   in_i,
  vhpf_stream_if.source out_o,
  vhpf_stream_if.sink   cfg_i
);
  import vhpf_pkg::*;

  localparam int unsigned SLOT_BITS  = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W      = 3 * AXIS_BITS;
  localparam int unsigned ENTRY_W    = 8 + KEY_W + SLOT_BITS + 16;
  localparam int unsigned CNT_W      = SLOT_BITS + 1;
  localparam int unsigned LOAD_LIMIT = TABLE_SLOTS * 7 / 10;
  localparam int unsigned HI_W       = PROD_W - SCALE_SHIFT - AXIS_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_ROUND = 8'b0000_1000,
    S_PRD   = 8'b0001_0000,
    S_PCHK  = 8'b0010_0000,
    S_CLEAR = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  typedef enum logic [1:0] {
    PH_POS   = 2'd0,
    PH_NRM   = 2'd1,
    PH_SCALE = 2'd2,
    PH_HASH  = 2'd3
  } phase_e;

  // Control state
  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [1:0]           row_q, row_d, idx_q, idx_d;
  logic                 round_q, round_d;
  logic                 err_q, err_d;
  logic                 zero_q, zero_d;
  logic                 clr_cmd_q, clr_cmd_d;
  logic [SLOT_BITS-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic [SLOT_BITS-1:0] repc_q, repc_d;

  // Configuration
  logic [47:0]        rot_q [3];
  logic [47:0]        rot_d [3];
  logic signed [31:0] sh_q [3];
  logic signed [31:0] sh_d [3];
  logic [23:0]        inv_q, inv_d;
  logic [15:0]        lim_q, lim_d;

  // Item data
  logic [1:0]                cmd_q, cmd_d;
  logic signed [31:0]        pin_q [3];
  logic signed [31:0]        pin_d [3];
  logic signed [15:0]        nin_q [3];
  logic signed [15:0]        nin_d [3];
  logic [15:0]               radius_q, radius_d;
  logic signed [PACC_W-1:0]  pacc_q [3];
  logic signed [PACC_W-1:0]  pacc_d [3];
  logic signed [NACC_W-1:0]  nacc_q [3];
  logic signed [NACC_W-1:0]  nacc_d [3];
  logic signed [31:0]        pos_q [3];
  logic signed [31:0]        pos_d [3];
  logic signed [15:0]        nrm_q [3];
  logic signed [15:0]        nrm_d [3];
  logic [KEY_W-1:0]          key_q, key_d;
  logic [63:0]               h_q, h_d, macc_q, macc_d;
  logic [SLOT_BITS-1:0]      slot_q, slot_d, pcnt_q, pcnt_d;
  logic [7:0]                tag_q, tag_d;
  logic [2:0]                outcome_q, outcome_d;
  logic [SLOT_BITS-1:0]      rep_q, rep_d;

  // Shared multiplier and table RAM
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     ram_we, ram_re;
  logic [SLOT_BITS-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [7:0]               rd_tag;
  logic [KEY_W-1:0]         rd_key;
  logic [SLOT_BITS-1:0]     rd_rep;
  logic [15:0]              rd_hits;

  logic in_fire, out_fire, cfg_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign cfg_i.ready = 1'b1;

  assign rd_tag  = ram_rdata[ENTRY_W-1 -: 8];
  assign rd_key  = ram_rdata[ENTRY_W-9 -: KEY_W];
  assign rd_rep  = ram_rdata[SLOT_BITS+15 : 16];
  assign rd_hits = ram_rdata[15:0];

  vhpf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  vhpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    logic [31:0] hx;
    logic [63:0] hc;
    hx = (idx_q == 2'd2) ? h_q[63:32] : h_q[31:0];
    hc = round_q ? HASH_C2 : HASH_C1;
    unique case (phase_q)
      PH_POS: begin
        mul_a = MUL_W'(coef(rot_q[row_q], idx_q));
        mul_b = MUL_W'(pin_q[idx_q]);
      end
      PH_NRM: begin
        mul_a = MUL_W'(coef(rot_q[row_q], idx_q));
        mul_b = MUL_W'(nin_q[idx_q]);
      end
      PH_SCALE: begin
        mul_a = MUL_W'(pos_q[idx_q]);
        mul_b = {{(MUL_W-24){1'b0}}, inv_q};
      end
      default: begin
        mul_a = {2'b00, hx};
        mul_b = (idx_q == 2'd1) ? {2'b00, hc[63:32]} : {2'b00, hc[31:0]};
      end
    endcase
  end

  always_comb begin
    logic signed [PACC_W-1:0] ps;
    logic signed [PACC_W-15:0] tp;
    logic signed [NACC_W-1:0] ns;
    logic signed [NACC_W-15:0] tn;
    logic [HI_W-1:0]          hi;
    logic [63:0]              term, m, kx;

    state_d = state_q;   phase_d = phase_q;   row_d = row_q;   idx_d = idx_q;
    round_d = round_q;   err_d = err_q;       zero_d = zero_q; clr_cmd_d = clr_cmd_q;
    clr_d = clr_q;       occ_d = occ_q;       repc_d = repc_q;
    inv_d = inv_q;       lim_d = lim_q;       cmd_d = cmd_q;   radius_d = radius_q;
    key_d = key_q;       h_d = h_q;           macc_d = macc_q; slot_d = slot_q;
    pcnt_d = pcnt_q;     tag_d = tag_q;       outcome_d = outcome_q; rep_d = rep_q;
    for (int r = 0; r < 3; r++) begin
      rot_d[r] = rot_q[r];   sh_d[r] = sh_q[r];     pin_d[r] = pin_q[r];
      nin_d[r] = nin_q[r];   pacc_d[r] = pacc_q[r]; nacc_d[r] = nacc_q[r];
      pos_d[r] = pos_q[r];   nrm_d[r] = nrm_q[r];
    end
    ram_we = 1'b0;  ram_re = 1'b0;  ram_waddr = slot_q;  ram_wdata = '0;
    ps = '0; tp = '0; ns = '0; tn = '0; hi = '0; term = '0; m = '0; kx = '0;

    if (cfg_fire) begin
      unique case (reg_e'(cfg_i.data.reg_index))
        REG_ROT_X:   rot_d[0] = cfg_i.data.wdata;
        REG_ROT_Y:   rot_d[1] = cfg_i.data.wdata;
        REG_ROT_Z:   rot_d[2] = cfg_i.data.wdata;
        REG_SHIFT_X: sh_d[0]  = cfg_i.data.wdata[31:0];
        REG_SHIFT_Y: sh_d[1]  = cfg_i.data.wdata[31:0];
        REG_SHIFT_Z: sh_d[2]  = cfg_i.data.wdata[31:0];
        REG_INV_VOX: inv_d    = cfg_i.data.wdata[23:0];
        REG_SAT_LIM: lim_d    = cfg_i.data.wdata[15:0];
        default:     inv_d    = inv_q;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
          if (clr_cmd_q) begin
            outcome_d = OC_CLEARED;
            state_d   = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cmd_d    = in_i.data.command;
          pin_d[0] = in_i.data.in_pos_x;
          pin_d[1] = in_i.data.in_pos_y;
          pin_d[2] = in_i.data.in_pos_z;
          nin_d[0] = in_i.data.in_norm_x;
          nin_d[1] = in_i.data.in_norm_y;
          nin_d[2] = in_i.data.in_norm_z;
          radius_d = in_i.data.in_radius;
          zero_d   = 1'b0;
          err_d    = 1'b0;
          rep_d    = '0;
          row_d    = 2'd0;
          idx_d    = 2'd0;
          phase_d  = PH_POS;
          for (int r = 0; r < 3; r++) begin
            pacc_d[r] = {{(PACC_W-46){sh_q[r][31]}}, sh_q[r], 14'b0};
            nacc_d[r] = '0;
          end
          case (in_i.data.command)
            CMD_FUSE: state_d = S_MUL;
            CMD_SEED: state_d = S_ROUND;
            CMD_CLEAR: begin
              zero_d    = 1'b1;
              occ_d     = '0;
              repc_d    = '0;
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = S_CLEAR;
            end
            default: begin
              // Unused command code: reported as a range error, table untouched.
              zero_d    = 1'b1;
              outcome_d = OC_RANGE;
              state_d   = S_OUT;
            end
          endcase
        end
      end

      S_MUL: state_d = S_ACC;

      S_ACC: begin
        state_d = S_MUL;
        unique case (phase_q)
          PH_POS: begin
            pacc_d[row_q] = pacc_q[row_q] + prod[PACC_W-1:0];
            if (idx_q == 2'd2) begin
              idx_d   = 2'd0;
              phase_d = PH_NRM;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
          PH_NRM: begin
            nacc_d[row_q] = nacc_q[row_q] + prod[NACC_W-1:0];
            if (idx_q == 2'd2) begin
              idx_d   = 2'd0;
              phase_d = PH_POS;
              if (row_q == 2'd2) begin
                state_d = S_ROUND;
              end else begin
                row_d = row_q + 2'd1;
              end
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
          PH_SCALE: begin
            // Index is floor(product / 2^28); in range when it fits AXIS_BITS signed.
            hi = prod[PROD_W-1 : SCALE_SHIFT+AXIS_BITS-1];
            key_d[idx_q*AXIS_BITS +: AXIS_BITS] =
              {~prod[SCALE_SHIFT+AXIS_BITS-1], prod[SCALE_SHIFT+AXIS_BITS-2 : SCALE_SHIFT]};
            if (!((&hi) || !(|hi))) begin
              err_d = 1'b1;
            end
            if (idx_q == 2'd2) begin
              if (err_d) begin
                outcome_d = OC_RANGE;
                state_d   = S_OUT;
              end else begin
                kx      = 64'(key_d);
                h_d     = kx ^ (kx >> 33);
                macc_d  = '0;
                round_d = 1'b0;
                idx_d   = 2'd0;
                phase_d = PH_HASH;
              end
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end
          default: begin
            // Low 64 bits of a 64 x 64 product from three 32 x 32 partials.
            term = (idx_q == 2'd0) ? prod[63:0] : {prod[31:0], 32'b0};
            m    = macc_q + term;
            if (idx_q == 2'd2) begin
              h_d    = m ^ (m >> 33);
              idx_d  = 2'd0;
              macc_d = '0;
              if (round_q) begin
                tag_d   = (h_d[63:56] == 8'd0) ? 8'd1 : h_d[63:56];
                slot_d  = h_d[SLOT_BITS-1:0];
                pcnt_d  = '0;
                state_d = S_PRD;
              end else begin
                round_d = 1'b1;
              end
            end else begin
              macc_d = m;
              idx_d  = idx_q + 2'd1;
            end
          end
        endcase
      end

      S_ROUND: begin
        for (int r = 0; r < 3; r++) begin
          ps = pacc_q[r] + PACC_W'(14'h2000);
          tp = ps[PACC_W-1:14];
          ns = nacc_q[r] + NACC_W'(14'h2000);
          tn = ns[NACC_W-1:14];
          if (cmd_q == CMD_SEED) begin
            pos_d[r] = pin_q[r];
            nrm_d[r] = nin_q[r];
          end else begin
            if ((&tp[PACC_W-15:31]) || !(|tp[PACC_W-15:31])) begin
              pos_d[r] = tp[31:0];
            end else begin
              pos_d[r] = tp[PACC_W-15] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            if ((&tn[NACC_W-15:15]) || !(|tn[NACC_W-15:15])) begin
              nrm_d[r] = tn[15:0];
            end else begin
              nrm_d[r] = tn[NACC_W-15] ? 16'sh8000 : 16'sh7fff;
            end
          end
        end
        key_d   = '0;
        idx_d   = 2'd0;
        phase_d = PH_SCALE;
        state_d = S_MUL;
      end

      S_PRD: begin
        ram_re  = 1'b1;
        state_d = S_PCHK;
      end

      S_PCHK: begin
        state_d = S_OUT;
        if (rd_tag == 8'd0) begin
          if (occ_q >= CNT_W'(LOAD_LIMIT)) begin
            outcome_d = OC_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {tag_q, key_q, repc_q, 16'd1};
            rep_d     = repc_q;
            occ_d     = occ_q + 1'b1;
            repc_d    = repc_q + 1'b1;
            outcome_d = (cmd_q == CMD_SEED) ? OC_SEEDED : OC_NEW;
          end
        end else if (rd_tag == tag_q && rd_key == key_q) begin
          rep_d = rd_rep;
          if (cmd_q == CMD_SEED) begin
            outcome_d = OC_SEED_DROP;
          end else if (rd_hits >= lim_q) begin
            outcome_d = OC_SAT;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {rd_tag, rd_key, rd_rep, rd_hits + 16'd1};
            outcome_d = OC_HIT;
          end
        end else if (pcnt_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
          outcome_d = OC_FULL;
        end else begin
          slot_d  = slot_q + 1'b1;
          pcnt_d  = pcnt_q + 1'b1;
          state_d = S_PRD;
        end
      end

      S_OUT: begin
        if (out_fire) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      phase_q   <= PH_POS;
      row_q     <= '0;
      idx_q     <= '0;
      round_q   <= 1'b0;
      err_q     <= 1'b0;
      zero_q    <= 1'b0;
      clr_cmd_q <= 1'b0;
      clr_q     <= '0;
      occ_q     <= '0;
      repc_q    <= '0;
      rot_q[0]  <= 48'd16384;
      rot_q[1]  <= 48'd16384 << 16;
      rot_q[2]  <= 48'd16384 << 32;
      sh_q[0]   <= '0;
      sh_q[1]   <= '0;
      sh_q[2]   <= '0;
      inv_q     <= 24'd65536;
      lim_q     <= 16'd3;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      row_q     <= row_d;
      idx_q     <= idx_d;
      round_q   <= round_d;
      err_q     <= err_d;
      zero_q    <= zero_d;
      clr_cmd_q <= clr_cmd_d;
      clr_q     <= clr_d;
      occ_q     <= occ_d;
      repc_q    <= repc_d;
      rot_q     <= rot_d;
      sh_q      <= sh_d;
      inv_q     <= inv_d;
      lim_q     <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pin_q     <= pin_d;
    nin_q     <= nin_d;
    radius_q  <= radius_d;
    pacc_q    <= pacc_d;
    nacc_q    <= nacc_d;
    pos_q     <= pos_d;
    nrm_q     <= nrm_d;
    key_q     <= key_d;
    h_q       <= h_d;
    macc_q    <= macc_d;
    slot_q    <= slot_d;
    pcnt_q    <= pcnt_d;
    tag_q     <= tag_d;
    outcome_q <= outcome_d;
    rep_q     <= rep_d;
  end

  // Clear and the unused command report zeros in the position, normal, radius and representative index fields.
  always_comb begin
    out_o.data.outcome    = outcome_q;
    out_o.data.kept       = (outcome_q == OC_HIT) || (outcome_q == OC_NEW);
    out_o.data.out_pos_x  = zero_q ? '0 : pos_q[0];
    out_o.data.out_pos_y  = zero_q ? '0 : pos_q[1];
    out_o.data.out_pos_z  = zero_q ? '0 : pos_q[2];
    out_o.data.out_norm_x = zero_q ? '0 : nrm_q[0];
    out_o.data.out_norm_y = zero_q ? '0 : nrm_q[1];
    out_o.data.out_norm_z = zero_q ? '0 : nrm_q[2];
    out_o.data.out_radius = zero_q ? '0 : radius_q;
    out_o.data.representative_index = zero_q ? '0 : REP_W'(rep_q);
    out_o.data.voxels_in_use = OCC_W'(occ_q);
  end

  `VHPF_ASSERT_NEVER(a_one_item_in_flight, clk_i, rst_ni, in_i.ready && out_o.valid)
  `VHPF_ASSERT_NEVER(a_load_limit, clk_i, rst_ni, occ_q > CNT_W'(LOAD_LIMIT))
  `VHPF_ASSERT(a_no_probe_after_range, clk_i, rst_ni, (state_q == S_PRD) |-> !err_q)

endmodule
